FILE: src/tpcs_pkg.sv
// Package: shared types, constants and register codes of the touch calibrate/smooth unit.
`default_nettype none

package tpcs_pkg;

    // Default plate size in whole mm
    localparam int PLATE_WIDTH_DEF  = 256;
    localparam int PLATE_HEIGHT_DEF = 256;

    // Field and port widths
    localparam int RAW_W      = 10;
    localparam int PRESS_W    = 12;
    localparam int POS_W      = 16;
    localparam int ALPHA_W    = 9;
    localparam int INV_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Internal datapath widths
    localparam int Q_W       = 24;  // Q16.8 filter state
    localparam int DIFF_W    = 12;  // signed raw differences
    localparam int MAG_W     = 11;  // magnitude of a raw difference
    localparam int MUL_A_W   = 12;
    localparam int MUL_B_W   = 25;
    localparam int PROD_W    = 37;
    localparam int SCALED_W  = 22;  // |num| * plate size
    localparam int DVD_W     = 35;  // scaled value with 13 fraction bits
    localparam int DIV_STEPS = 35;
    localparam int DIV_CNT_W = 6;

    localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = -24'sh800000;
    localparam logic [ALPHA_W-1:0]    ALPHA_ONE = 9'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESSURE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd6;

    // Register reset values
    localparam logic [PRESS_W-1:0] MIN_PRESSURE_RST = 12'd10;
    localparam logic [RAW_W-1:0]   RAW_MIN_RST      = 10'd0;
    localparam logic [RAW_W-1:0]   RAW_MAX_RST      = 10'd1023;
    localparam logic [INV_W-1:0]   INVERT_RST       = 2'd0;
    localparam logic [ALPHA_W-1:0] ALPHA_RST        = 9'd64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_DIV,
        ST_FIX,
        ST_SEED,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

FILE: src/touch_position_calibrate_smooth_unit.sv
// Top level: touch sample calibration and exponential smoothing on one shared multiplier/divider.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------
//  sample   in         i_valid / o_stall    i_raw_x, i_raw_y, i_pressure
//  result   out        o_valid / i_stall    o_valid_res, o_pos_x, o_pos_y
//  config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A touched sample runs, per axis, a multiply step, 35 steps of the shared restoring
// divider and a rounding step, then multiply-accumulate steps per axis (a seed step
// instead for the first touch) and a write step. An axis with equal span ends skips
// its divide and rounding. A sample below the pressure threshold goes from idle
// straight to the write state.
// Reset (synchronous, active low) loads the register defaults and clears the filter.
// A stalled result holds in the output register; the sequencer waits in its write
// state until that register frees up, and the input stalls whenever it is not idle.
`default_nettype none

module touch_position_calibrate_smooth_unit #(
    parameter int PLATE_WIDTH  = tpcs_pkg::PLATE_WIDTH_DEF,
    parameter int PLATE_HEIGHT = tpcs_pkg::PLATE_HEIGHT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // sample channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [tpcs_pkg::RAW_W-1:0]          i_raw_x,
    input  wire logic [tpcs_pkg::RAW_W-1:0]          i_raw_y,
    input  wire logic [tpcs_pkg::PRESS_W-1:0]        i_pressure,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_valid_res,
    output logic signed [tpcs_pkg::POS_W-1:0]        o_pos_x,
    output logic signed [tpcs_pkg::POS_W-1:0]        o_pos_y,
    // configuration port
    input  wire logic                                i_cfg_we,
    input  wire logic [tpcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tpcs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int Q_W    = tpcs_pkg::Q_W;
    localparam int PROD_W = tpcs_pkg::PROD_W;

    // Plate scale factors: multiplier operand and half span in Q16.8
    localparam logic signed [tpcs_pkg::MUL_B_W-1:0] X_SCALE = 25'(PLATE_WIDTH);
    localparam logic signed [tpcs_pkg::MUL_B_W-1:0] Y_SCALE = 25'(PLATE_HEIGHT);
    localparam logic signed [PROD_W-1:0] X_OFFSET = 37'(PLATE_WIDTH * 2048);
    localparam logic signed [PROD_W-1:0] Y_OFFSET = 37'(PLATE_HEIGHT * 2048);

    // Saturate a wide signed value to Q16.8
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 37'(tpcs_pkg::Q_MAX)) begin
            r = tpcs_pkg::Q_MAX;
        end else if (v < 37'(tpcs_pkg::Q_MIN)) begin
            r = tpcs_pkg::Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // Round Q16.8 to whole 1/16 mm and saturate to 16 bits
    function automatic logic signed [tpcs_pkg::POS_W-1:0] round_pos(
        input logic signed [Q_W-1:0] s
    );
        logic signed [Q_W:0]   t;
        logic signed [16:0]    p;
        logic signed [tpcs_pkg::POS_W-1:0] r;
        t = 25'(s) + 25'sd128;
        p = t[Q_W:8];
        if (p > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (p < -17'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = p[15:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [tpcs_pkg::PRESS_W-1:0] r_min_pressure;
    logic [tpcs_pkg::RAW_W-1:0]   r_x_min;
    logic [tpcs_pkg::RAW_W-1:0]   r_x_max;
    logic [tpcs_pkg::RAW_W-1:0]   r_y_min;
    logic [tpcs_pkg::RAW_W-1:0]   r_y_max;
    logic [tpcs_pkg::INV_W-1:0]   r_invert;
    logic [tpcs_pkg::ALPHA_W-1:0] r_alpha;

    // Sequencer and datapath registers
    tpcs_pkg::t_state r_state;
    tpcs_pkg::t_state n_state;
    logic [tpcs_pkg::RAW_W-1:0]     r_raw_x;
    logic [tpcs_pkg::RAW_W-1:0]     r_raw_y;
    logic                           r_touch;
    logic                           r_axis;
    logic                           r_neg;
    logic [tpcs_pkg::MAG_W-1:0]     r_dmag;
    logic [tpcs_pkg::MAG_W-1:0]     r_rem;
    logic [tpcs_pkg::DVD_W-1:0]     r_dvd;
    logic [tpcs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic signed [Q_W-1:0]          r_map_x;
    logic signed [Q_W-1:0]          r_map_y;
    logic signed [Q_W-1:0]          r_smooth_x;
    logic signed [Q_W-1:0]          r_smooth_y;
    logic                           r_primed;
    logic signed [PROD_W-1:0]       r_acc;

    // Output register
    logic                             r_out_valid;
    logic                             r_out_valid_res;
    logic signed [tpcs_pkg::POS_W-1:0] r_out_pos_x;
    logic signed [tpcs_pkg::POS_W-1:0] r_out_pos_y;

    // Combinational datapath
    logic                               accept;
    logic                               out_free;
    logic [tpcs_pkg::RAW_W-1:0]         sel_raw;
    logic [tpcs_pkg::RAW_W-1:0]         sel_lo;
    logic [tpcs_pkg::RAW_W-1:0]         sel_hi;
    logic                               sel_inv;
    logic signed [tpcs_pkg::MUL_B_W-1:0] sel_scale;
    logic signed [PROD_W-1:0]           sel_offset;
    logic signed [Q_W-1:0]              sel_map;
    logic signed [Q_W-1:0]              sel_smooth;
    logic signed [tpcs_pkg::DIFF_W-1:0] d;
    logic signed [tpcs_pkg::DIFF_W-1:0] den;
    logic signed [tpcs_pkg::DIFF_W-1:0] num;
    logic [tpcs_pkg::MAG_W-1:0]         num_mag;
    logic [tpcs_pkg::MAG_W-1:0]         den_mag;
    logic                               den_zero;
    logic [tpcs_pkg::ALPHA_W-1:0]       alpha_eff;
    logic signed [tpcs_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tpcs_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]           mul_p;
    logic [tpcs_pkg::DIFF_W:0]          div_diff;
    logic                               div_ge;
    logic [tpcs_pkg::DVD_W:0]           q_inc;
    logic signed [PROD_W-1:0]           q_signed;
    logic signed [Q_W-1:0]              fix_val;
    logic signed [PROD_W-1:0]           blend_sum;
    logic signed [Q_W-1:0]              blend_val;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Select the axis being worked on
    always_comb begin
        if (r_axis) begin
            sel_raw    = r_raw_y;
            sel_lo     = r_y_min;
            sel_hi     = r_y_max;
            sel_inv    = r_invert[1];
            sel_scale  = Y_SCALE;
            sel_offset = Y_OFFSET;
            sel_map    = r_map_y;
            sel_smooth = r_smooth_y;
        end else begin
            sel_raw    = r_raw_x;
            sel_lo     = r_x_min;
            sel_hi     = r_x_max;
            sel_inv    = r_invert[0];
            sel_scale  = X_SCALE;
            sel_offset = X_OFFSET;
            sel_map    = r_map_x;
            sel_smooth = r_smooth_x;
        end
    end

    // Span differences and numerator of the linear map
    assign d        = $signed({2'b00, sel_raw}) - $signed({2'b00, sel_lo});
    assign den      = $signed({2'b00, sel_hi}) - $signed({2'b00, sel_lo});
    assign num      = sel_inv ? (den - d) : d;
    assign num_mag  = num[tpcs_pkg::DIFF_W-1] ? 11'(-num) : num[tpcs_pkg::MAG_W-1:0];
    assign den_mag  = den[tpcs_pkg::DIFF_W-1] ? 11'(-den) : den[tpcs_pkg::MAG_W-1:0];
    assign den_zero = (den == '0);

    assign alpha_eff = (r_alpha > tpcs_pkg::ALPHA_ONE) ? tpcs_pkg::ALPHA_ONE : r_alpha;

    // Shared multiplier operand selection
    always_comb begin
        case (r_state)
            tpcs_pkg::ST_BLEND_A: begin
                mul_a = $signed({3'b000, alpha_eff});
                mul_b = 25'(sel_map);
            end
            tpcs_pkg::ST_BLEND_B: begin
                mul_a = $signed({3'b000, tpcs_pkg::ALPHA_ONE - alpha_eff});
                mul_b = 25'(sel_smooth);
            end
            default: begin
                mul_a = $signed({1'b0, num_mag});
                mul_b = sel_scale;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring divider step: one quotient bit a cycle
    assign div_diff = {1'b0, r_rem, r_dvd[tpcs_pkg::DVD_W-1]} - {2'b00, r_dmag};
    assign div_ge   = !div_diff[tpcs_pkg::DIFF_W];

    // Round half up from the quotient with one extra fraction bit, apply sign, recenter
    assign q_inc    = {1'b0, r_dvd} + 36'd1;
    assign q_signed = r_neg ? -$signed({2'b00, q_inc[tpcs_pkg::DVD_W:1]})
                            :  $signed({2'b00, q_inc[tpcs_pkg::DVD_W:1]});
    assign fix_val  = sat_q(q_signed - sel_offset);

    // Blend: accumulate the second product, round and floor by 256
    assign blend_sum = r_acc + mul_p + 37'sd128;
    assign blend_val = sat_q(blend_sum >>> 8);

    // Next state and handshake
    always_comb begin
        n_state = r_state;
        o_stall = (r_state != tpcs_pkg::ST_IDLE);
        case (r_state)
            tpcs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_pressure >= r_min_pressure) ? tpcs_pkg::ST_MAP
                                                             : tpcs_pkg::ST_WRITE;
                end
            end
            tpcs_pkg::ST_MAP: begin
                if (!den_zero) begin
                    n_state = tpcs_pkg::ST_DIV;
                end else if (!r_axis) begin
                    n_state = tpcs_pkg::ST_MAP;
                end else begin
                    n_state = r_primed ? tpcs_pkg::ST_BLEND_A : tpcs_pkg::ST_SEED;
                end
            end
            tpcs_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = tpcs_pkg::ST_FIX;
                end
            end
            tpcs_pkg::ST_FIX: begin
                if (!r_axis) begin
                    n_state = tpcs_pkg::ST_MAP;
                end else begin
                    n_state = r_primed ? tpcs_pkg::ST_BLEND_A : tpcs_pkg::ST_SEED;
                end
            end
            tpcs_pkg::ST_SEED: begin
                n_state = tpcs_pkg::ST_WRITE;
            end
            tpcs_pkg::ST_BLEND_A: begin
                n_state = tpcs_pkg::ST_BLEND_B;
            end
            tpcs_pkg::ST_BLEND_B: begin
                n_state = r_axis ? tpcs_pkg::ST_WRITE : tpcs_pkg::ST_BLEND_A;
            end
            tpcs_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = tpcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpcs_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pressure <= tpcs_pkg::MIN_PRESSURE_RST;
            r_x_min        <= tpcs_pkg::RAW_MIN_RST;
            r_x_max        <= tpcs_pkg::RAW_MAX_RST;
            r_y_min        <= tpcs_pkg::RAW_MIN_RST;
            r_y_max        <= tpcs_pkg::RAW_MAX_RST;
            r_invert       <= tpcs_pkg::INVERT_RST;
            r_alpha        <= tpcs_pkg::ALPHA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpcs_pkg::CFG_MIN_PRESSURE: r_min_pressure <= i_cfg_data;
                tpcs_pkg::CFG_RAW_X_MIN:    r_x_min  <= i_cfg_data[tpcs_pkg::RAW_W-1:0];
                tpcs_pkg::CFG_RAW_X_MAX:    r_x_max  <= i_cfg_data[tpcs_pkg::RAW_W-1:0];
                tpcs_pkg::CFG_RAW_Y_MIN:    r_y_min  <= i_cfg_data[tpcs_pkg::RAW_W-1:0];
                tpcs_pkg::CFG_RAW_Y_MAX:    r_y_max  <= i_cfg_data[tpcs_pkg::RAW_W-1:0];
                tpcs_pkg::CFG_INVERT_MASK:  r_invert <= i_cfg_data[tpcs_pkg::INV_W-1:0];
                tpcs_pkg::CFG_FILTER_ALPHA: r_alpha  <= i_cfg_data[tpcs_pkg::ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_x <= '0;
            r_smooth_y <= '0;
            r_primed   <= 1'b0;
        end else begin
            case (r_state)
                tpcs_pkg::ST_SEED: begin
                    r_smooth_x <= r_map_x;
                    r_smooth_y <= r_map_y;
                    r_primed   <= 1'b1;
                end
                tpcs_pkg::ST_BLEND_B: begin
                    if (r_axis) begin
                        r_smooth_y <= blend_val;
                    end else begin
                        r_smooth_x <= blend_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers: sample latch, map, divider and accumulator
    always_ff @(posedge i_clk) begin
        case (r_state)
            tpcs_pkg::ST_IDLE: begin
                if (accept) begin
                    r_raw_x <= i_raw_x;
                    r_raw_y <= i_raw_y;
                    r_touch <= (i_pressure >= r_min_pressure);
                    r_axis  <= 1'b0;
                end
            end
            tpcs_pkg::ST_MAP: begin
                if (den_zero) begin
                    // Degenerate span maps to zero
                    if (r_axis) begin
                        r_map_y <= '0;
                    end else begin
                        r_map_x <= '0;
                    end
                    r_axis <= ~r_axis;
                end else begin
                    r_dvd  <= {mul_p[tpcs_pkg::SCALED_W-1:0], 13'd0};
                    r_rem  <= '0;
                    r_dmag <= den_mag;
                    r_neg  <= num[tpcs_pkg::DIFF_W-1] ^ den[tpcs_pkg::DIFF_W-1];
                    r_cnt  <= 6'(tpcs_pkg::DIV_STEPS - 1);
                end
            end
            tpcs_pkg::ST_DIV: begin
                r_rem <= div_ge ? div_diff[tpcs_pkg::MAG_W-1:0]
                                : {r_rem[tpcs_pkg::MAG_W-2:0], r_dvd[tpcs_pkg::DVD_W-1]};
                r_dvd <= {r_dvd[tpcs_pkg::DVD_W-2:0], div_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            tpcs_pkg::ST_FIX: begin
                if (r_axis) begin
                    r_map_y <= fix_val;
                end else begin
                    r_map_x <= fix_val;
                end
                r_axis <= ~r_axis;
            end
            tpcs_pkg::ST_BLEND_A: begin
                r_acc <= mul_p;
            end
            tpcs_pkg::ST_BLEND_B: begin
                r_axis <= ~r_axis;
            end
            default: begin
            end
        endcase
    end

    // Output register: load in the write state, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tpcs_pkg::ST_WRITE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tpcs_pkg::ST_WRITE && out_free) begin
            r_out_valid_res <= r_touch;
            r_out_pos_x     <= r_touch ? round_pos(r_smooth_x) : '0;
            r_out_pos_y     <= r_touch ? round_pos(r_smooth_y) : '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_valid_res;
    assign o_pos_x     = r_out_pos_x;
    assign o_pos_y     = r_out_pos_y;

endmodule

`default_nettype wire

FILE: dv/tpcs_result_checker.sv
// Checker: predicts calibrated, smoothed touch positions from sample transfers and compares.
module tpcs_result_checker
    import tpcs_pkg::*;
#(
    parameter int PLATE_WIDTH  = PLATE_WIDTH_DEF,
    parameter int PLATE_HEIGHT = PLATE_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  o_stall,
    input  wire logic [RAW_W-1:0]      i_raw_x,
    input  wire logic [RAW_W-1:0]      i_raw_y,
    input  wire logic [PRESS_W-1:0]    i_pressure,
    input  wire logic                  o_valid,
    input  wire logic                  i_stall,
    input  wire logic                  o_valid_res,
    input  wire logic [POS_W-1:0]      o_pos_x,
    input  wire logic [POS_W-1:0]      o_pos_y,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    localparam int     REPORT_MAX = 10;
    localparam longint X_HALF     = longint'(PLATE_WIDTH) * 8;
    localparam longint Y_HALF     = longint'(PLATE_HEIGHT) * 8;
    localparam longint Q_HI       = longint'(Q_MAX);
    localparam longint Q_LO       = longint'(Q_MIN);

    typedef struct packed {
        logic                    valid_res;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_touch_pos;

    // Shadow copy of the calibration registers
    logic [PRESS_W-1:0] thr;
    logic [RAW_W-1:0]   x_lo, x_hi, y_lo, y_hi;
    logic [INV_W-1:0]   invert;
    logic [ALPHA_W-1:0] alpha;

    // Shadow filter state, Q16.8
    longint sx, sy;
    bit     primed;

    t_touch_pos pending_positions[$];

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Map a raw reading onto the centered plate span, rounding half away from zero
    function automatic longint plate_coord(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                           logic [RAW_W-1:0] hi, longint half, bit flip);
        longint d, den, num, prod, mag, dmag, q;
        d   = longint'(raw) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (den == 0) return 0;
        num  = flip ? den - d : d;
        prod = num * half * 512;
        mag  = (prod < 0) ? -prod : prod;
        dmag = (den < 0) ? -den : den;
        q    = (2 * mag + dmag) / (2 * dmag);
        if ((prod < 0) != (den < 0)) q = -q;
        return clip(q - half * 256, Q_LO, Q_HI);
    endfunction

    // Advance the smoothing filter by one sample and return the position it reports
    function automatic t_touch_pos filtered_position(logic [RAW_W-1:0] rx,
                                                     logic [RAW_W-1:0] ry,
                                                     logic [PRESS_W-1:0] pr);
        t_touch_pos r;
        longint mx, my, w;
        r = '0;
        if (pr < thr) return r;
        mx = plate_coord(rx, x_lo, x_hi, X_HALF, invert[0]);
        my = plate_coord(ry, y_lo, y_hi, Y_HALF, invert[1]);
        if (!primed) begin
            sx     = mx;
            sy     = my;
            primed = 1'b1;
        end else begin
            w  = (alpha > ALPHA_ONE) ? 256 : longint'(alpha);
            sx = clip((w * mx + (256 - w) * sx + 128) >>> 8, Q_LO, Q_HI);
            sy = clip((w * my + (256 - w) * sy + 128) >>> 8, Q_LO, Q_HI);
        end
        r.valid_res = 1'b1;
        r.pos_x     = POS_W'(clip((sx + 128) >>> 8, -32768, 32767));
        r.pos_y     = POS_W'(clip((sy + 128) >>> 8, -32768, 32767));
        return r;
    endfunction

    initial o_mismatches = 0;

    // Track config writes, compare result transfers, queue predictions for sample transfers
    always @(posedge i_clk) begin
        t_touch_pos want;
        if (!i_rst_n) begin
            thr           = MIN_PRESSURE_RST;
            x_lo          = RAW_MIN_RST;
            x_hi          = RAW_MAX_RST;
            y_lo          = RAW_MIN_RST;
            y_hi          = RAW_MAX_RST;
            invert        = INVERT_RST;
            alpha         = ALPHA_RST;
            sx            = 0;
            sy            = 0;
            primed        = 1'b0;
            pending_positions.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_PRESSURE: thr    = i_cfg_data[PRESS_W-1:0];
                    CFG_RAW_X_MIN:    x_lo   = i_cfg_data[RAW_W-1:0];
                    CFG_RAW_X_MAX:    x_hi   = i_cfg_data[RAW_W-1:0];
                    CFG_RAW_Y_MIN:    y_lo   = i_cfg_data[RAW_W-1:0];
                    CFG_RAW_Y_MAX:    y_hi   = i_cfg_data[RAW_W-1:0];
                    CFG_INVERT_MASK:  invert = i_cfg_data[INV_W-1:0];
                    CFG_FILTER_ALPHA: alpha  = i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (pending_positions.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_MAX)
                        $display("unexpected result: valid=%0d x=%0d y=%0d", o_valid_res,
                                 $signed(o_pos_x), $signed(o_pos_y));
                end else begin
                    want = pending_positions.pop_front();
                    if (o_valid_res !== want.valid_res || o_pos_x !== want.pos_x ||
                        o_pos_y !== want.pos_y) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_MAX)
                            $display({"mismatch: expected valid=%0d x=%0d y=%0d, ",
                                      "got valid=%0d x=%0d y=%0d"},
                                     want.valid_res, want.pos_x, want.pos_y, o_valid_res,
                                     $signed(o_pos_x), $signed(o_pos_y));
                    end
                end
            end
            if (i_valid && !o_stall)
                pending_positions.push_back(filtered_position(i_raw_x, i_raw_y, i_pressure));
            o_outstanding <= pending_positions.size();
        end
    end

endmodule

FILE: dv/tb_touch_position_calibrate_smooth_unit.sv
// Testbench top: drives touch samples and calibration settings, gives the verdict.
module tb_touch_position_calibrate_smooth_unit;
    import tpcs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 200;
    localparam int SETS_PER_PHASE = 3;
    localparam int ITEMS_PER_SET  = 50;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic [RAW_W-1:0]      i_raw_x    = '0;
    logic [RAW_W-1:0]      i_raw_y    = '0;
    logic [PRESS_W-1:0]    i_pressure = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic                  o_valid_res;
    logic [POS_W-1:0]      o_pos_x;
    logic [POS_W-1:0]      o_pos_y;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatches, outstanding;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_ask      = 0;
    int hold_seen     = 0;

    // Current calibration, used to aim the random samples
    logic [PRESS_W-1:0] cur_thr = MIN_PRESSURE_RST;
    logic [RAW_W-1:0]   cur_x_lo = RAW_MIN_RST, cur_x_hi = RAW_MAX_RST;
    logic [RAW_W-1:0]   cur_y_lo = RAW_MIN_RST, cur_y_hi = RAW_MAX_RST;

    touch_position_calibrate_smooth_unit dut (.*);

    tpcs_result_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_raw_x, .i_raw_y, .i_pressure,
        .o_valid, .i_stall, .o_valid_res, .o_pos_x, .o_pos_y,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_mismatches(mismatches), .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one sample, after a random idle gap, and hold it until the transfer
    task automatic send_sample(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                               input logic [PRESS_W-1:0] pr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_x    <= rx;
        i_raw_y    <= ry;
        i_pressure <= pr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write all registers, with junk above each register's width, plus the unused index
    task automatic apply_setting(input logic [PRESS_W-1:0] thr,
                                 input logic [RAW_W-1:0] xl, input logic [RAW_W-1:0] xh,
                                 input logic [RAW_W-1:0] yl, input logic [RAW_W-1:0] yh,
                                 input logic [INV_W-1:0] inv, input logic [ALPHA_W-1:0] a);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        put_reg(CFG_MIN_PRESSURE, thr);
        put_reg(CFG_RAW_X_MIN, (junk << RAW_W) | xl);
        put_reg(CFG_RAW_X_MAX, (junk << RAW_W) | xh);
        put_reg(CFG_RAW_Y_MIN, (junk << RAW_W) | yl);
        put_reg(CFG_RAW_Y_MAX, (junk << RAW_W) | yh);
        put_reg(CFG_INVERT_MASK, (junk << INV_W) | inv);
        put_reg(CFG_FILTER_ALPHA, (junk << ALPHA_W) | a);
        put_reg(CFG_UNUSED, junk);
        i_cfg_we <= 1'b0;
        cur_thr  = thr;
        cur_x_lo = xl;
        cur_x_hi = xh;
        cur_y_lo = yl;
        cur_y_hi = yh;
    endtask

    // Mostly ordinary spans, some full, equal, reversed or one count wide
    task automatic pick_span(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) begin
            lo = RAW_W'($urandom_range(900));
            hi = RAW_W'($urandom_range(1023, lo + 1));
        end else if (roll < 70) begin
            lo = '0;
            hi = '1;
        end else if (roll < 80) begin
            lo = RAW_W'($urandom_range(1023));
            hi = lo;
        end else if (roll < 90) begin
            hi = RAW_W'($urandom_range(900));
            lo = RAW_W'($urandom_range(1023, hi + 1));
        end else begin
            lo = RAW_W'($urandom_range(1022));
            hi = lo + 1'b1;
            if (roll[0]) {lo, hi} = {hi, lo};
        end
    endtask

    task automatic random_setting();
        logic [PRESS_W-1:0] thr;
        logic [RAW_W-1:0]   xl, xh, yl, yh;
        logic [ALPHA_W-1:0] a;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 15)      thr = '0;
        else if (roll < 20) thr = '1;
        else if (roll < 70) thr = PRESS_W'($urandom_range(40));
        else                thr = PRESS_W'($urandom_range(4095));
        pick_span(xl, xh);
        pick_span(yl, yh);
        roll = $urandom_range(99);
        if (roll < 10)      a = '0;
        else if (roll < 20) a = ALPHA_ONE;
        else if (roll < 30) a = ALPHA_W'($urandom_range(511, 257));
        else if (roll < 35) a = 9'd1;
        else                a = ALPHA_W'($urandom_range(255));
        apply_setting(thr, xl, xh, yl, yh, INV_W'($urandom_range(3)), a);
    endtask

    // Mostly inside the span, some at the converter extremes, some anywhere
    function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return RAW_W'($urandom_range(hi, lo));
        if (roll < 85) return {RAW_W{roll[0]}};
        return RAW_W'($urandom_range(1023));
    endfunction

    task automatic send_random_sample();
        logic [PRESS_W-1:0] pr;
        if (cur_thr != 0 && $urandom_range(99) < 20)
            pr = PRESS_W'($urandom_range(cur_thr - 1));
        else
            pr = PRESS_W'($urandom_range(4095, cur_thr));
        send_sample(pick_raw(cur_x_lo, cur_x_hi), pick_raw(cur_y_lo, cur_y_hi), pr);
    endtask

    // Result side: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Abort when no transfer happens on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: below, at and above threshold, first touch seeds the filter
        send_sample(10'd0, 10'd0, 12'd0);
        send_sample(10'd512, 10'd512, 12'd9);
        send_sample(10'd0, 10'd1023, 12'd10);
        send_sample(10'd1023, 10'd0, 12'd4095);
        send_sample(10'd511, 10'd512, 12'd2048);
        send_sample(10'd1023, 10'd1023, 12'd4095);
        settle();

        // Equal x span ends, reversed y span, both inverted, alpha of one
        apply_setting(12'd0, 10'd300, 10'd300, 10'd1023, 10'd0, 2'd3, ALPHA_ONE);
        send_sample(10'd300, 10'd0, 12'd0);
        send_sample(10'd0, 10'd1023, 12'd1);
        send_sample(10'd1023, 10'd512, 12'd4095);
        send_sample(10'd5, 10'd700, 12'd100);
        settle();

        // Top threshold, one-count spans driving the map into saturation, alpha zero
        apply_setting(12'd4095, 10'd0, 10'd1, 10'd1022, 10'd1023, 2'd1, 9'd0);
        send_sample(10'd1023, 10'd0, 12'd4095);
        send_sample(10'd0, 10'd1023, 12'd4094);
        send_sample(10'd1023, 10'd1023, 12'd4095);
        settle();

        // Alpha above one, x saturating high
        apply_setting(12'd0, 10'd0, 10'd1, 10'd1023, 10'd0, 2'd2, 9'd511);
        send_sample(10'd1023, 10'd0, 12'd4095);
        send_sample(10'd0, 10'd1023, 12'd0);
        send_sample(10'd1023, 10'd1023, 12'd17);
        settle();

        // Reversed x span, inverted y saturating low, tiny alpha
        apply_setting(12'd1, 10'd1023, 10'd0, 10'd0, 10'd1, 2'd2, 9'd1);
        send_sample(10'd0, 10'd1023, 12'd0);
        send_sample(10'd0, 10'd1023, 12'd1);
        send_sample(10'd1023, 10'd1023, 12'd4095);
        send_sample(10'd512, 10'd0, 12'd2);
        settle();

        // Random settings under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            for (int s = 0; s < SETS_PER_PHASE; s++) begin
                random_setting();
                // Hold the result side off while samples keep coming, so the input backs up
                if (phase == 0 && s == 0) hold_ask++;
                repeat (ITEMS_PER_SET) send_random_sample();
                settle();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
